// File: design/pbts_pkg.sv
// Shared constants for the priority bitmap thread scheduler.
package pbts_pkg;
    localparam int MAX_THREADS_DEF     = 16;
    localparam int PRIORITY_LEVELS_DEF = 32;

    localparam logic [2:0] KIND_CREATE   = 3'd0;
    localparam logic [2:0] KIND_READY    = 3'd1;
    localparam logic [2:0] KIND_REMOVE   = 3'd2;
    localparam logic [2:0] KIND_START    = 3'd3;
    localparam logic [2:0] KIND_SCHEDULE = 3'd4;
    localparam logic [2:0] KIND_TICK     = 3'd5;

    localparam logic [1:0] ST_NOT_READY = 2'd0;
    localparam logic [1:0] ST_READY     = 2'd1;
    localparam logic [1:0] ST_RUNNING   = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_NO_READY = 2'd1;
    localparam logic [1:0] ERR_NO_CUR   = 2'd2;
endpackage

// File: design/priority_bitmap_thread_scheduler_top.sv
// Top level of the priority bitmap thread scheduler.
//
// Usage: each transfer on the s_ channel is one scheduler operation
// (create, ready again, remove, start, schedule, tick). Every operation
// yields exactly one result transfer on the m_ channel with the switch
// decision, the running thread and an error code.
// The per-thread slice state (length and time left) lies in synchronous
// RAMs; link lists, priorities and status live in small flip-flop tables.
// After acceptance an operation passes through a slice RAM read state and a
// compute state; a start or a switch adds one more state to unlink the picked
// thread. The result sits in an output register.
// A new operation is accepted only when the block is idle and the output
// register is empty, so the block does not take a new operation before the
// last result has been taken.
// At reset the ready bitmap, all thread status, the running thread and the
// output valid flag are cleared; no clearing pass is needed. A stalled
// receiver holds the result stable and keeps s_tready low until it is taken.
module priority_bitmap_thread_scheduler_top #(
    parameter int MAX_THREADS     = pbts_pkg::MAX_THREADS_DEF,
    parameter int PRIORITY_LEVELS = pbts_pkg::PRIORITY_LEVELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[2:0], thread_id[6:3], priority_req[11:7], slice_ticks[27:12], zero pad
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // switched[0], from_thread[4:1], to_thread[8:5], running_valid[9],
    // error_code[11:10], zero pad
    output logic [15:0] m_tdata
);
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_EXEC = 3'd2,
                           S_SCHED = 3'd3;

    logic [2:0] state_reg;
    logic [2:0] kind_reg;
    logic [3:0] tid_reg;
    logic [4:0] prio_reg;
    logic [15:0] slice_reg;

    logic [PRIORITY_LEVELS-1:0] bitmap_reg;
    logic [TW-1:0] head_reg [PRIORITY_LEVELS];
    logic [TW:0]   next_reg [MAX_THREADS];   // MSB set marks end of list
    logic [TW:0]   prev_reg [MAX_THREADS];
    logic [LW-1:0] tprio_reg [MAX_THREADS];
    logic [1:0]    status_reg [MAX_THREADS];
    logic [TW-1:0] run_reg;
    logic          run_valid_reg;
    logic [TW-1:0] pick_reg;

    logic          out_valid_reg;
    logic [11:0]   out_reg;

    // Slice RAMs, read at the running thread and written at the thread that the operation works on.
    logic [TW-1:0] slice_addr;
    logic          len_we, left_we;
    logic [15:0]   len_wdata, left_wdata, len_rdata, left_rdata;
    logic [TW-1:0] len_waddr, left_waddr;

    pbts_ram #(.WIDTH(16), .DEPTH(MAX_THREADS)) u_len (
        .aclk(aclk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(slice_addr), .rdata(len_rdata));
    pbts_ram #(.WIDTH(16), .DEPTH(MAX_THREADS)) u_left (
        .aclk(aclk), .we(left_we), .waddr(left_waddr), .wdata(left_wdata),
        .raddr(slice_addr), .rdata(left_rdata));

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    logic id_ok;
    logic [TW-1:0] tid_t;
    assign id_ok = ({28'd0, tid_reg} < MAX_THREADS);
    assign tid_t = TW'(tid_reg);
    assign slice_addr = run_reg;

    // Lowest set bitmap bit.
    logic [LW-1:0] best_lvl;
    always_comb begin
        best_lvl = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (bitmap_reg[i]) begin
                best_lvl = LW'(i);
            end
        end
    end
    logic [TW-1:0] best_t;
    assign best_t = head_reg[best_lvl];

    logic [LW-1:0] sat_prio;
    assign sat_prio = ({27'd0, prio_reg} >= PRIORITY_LEVELS) ?
                      LW'(PRIORITY_LEVELS - 1) : prio_reg[LW-1:0];

    // Next-state copies of the list tables, edited by one operation.
    logic [PRIORITY_LEVELS-1:0] bm_n;
    logic [TW-1:0] head_n [PRIORITY_LEVELS];
    logic [TW:0]   next_n [MAX_THREADS];
    logic [TW:0]   prev_n [MAX_THREADS];
    logic [LW-1:0] tprio_n [MAX_THREADS];
    logic [1:0]    status_n [MAX_THREADS];
    logic [TW-1:0] run_n;
    logic          run_valid_n;
    logic [2:0]    state_n;
    logic          out_load;
    logic          sw_n;
    logic [TW-1:0] from_n;
    logic [1:0]    err_n;

    always_comb begin
        logic [TW:0] p, n, o;
        logic [LW-1:0] lv;
        logic [TW-1:0] cur;
        bm_n = bitmap_reg;
        head_n = head_reg;
        next_n = next_reg;
        prev_n = prev_reg;
        tprio_n = tprio_reg;
        status_n = status_reg;
        run_n = run_reg;
        run_valid_n = run_valid_reg;
        state_n = state_reg;
        out_load = 1'b0;
        sw_n = 1'b0;
        from_n = '0;
        err_n = pbts_pkg::ERR_OK;
        len_we = 1'b0;
        left_we = 1'b0;
        len_waddr = tid_t;
        left_waddr = tid_t;
        len_wdata = slice_reg;
        left_wdata = slice_reg;
        p = '0; n = '0; o = '0; lv = '0;
        cur = run_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_n = S_READ;
                end
            end
            S_READ: begin
                state_n = S_EXEC;
            end
            S_EXEC: begin
                state_n = S_IDLE;
                out_load = 1'b1;
                case (kind_reg)
                    pbts_pkg::KIND_CREATE, pbts_pkg::KIND_READY, pbts_pkg::KIND_REMOVE: begin
                        if (id_ok && !(kind_reg == pbts_pkg::KIND_READY &&
                                       status_reg[tid_t] == pbts_pkg::ST_RUNNING)) begin
                            if (status_reg[tid_t] == pbts_pkg::ST_READY) begin
                                lv = tprio_reg[tid_t];
                                p = prev_reg[tid_t];
                                n = next_reg[tid_t];
                                if (!p[TW]) next_n[p[TW-1:0]] = n;
                                else head_n[lv] = n[TW-1:0];
                                if (!n[TW]) prev_n[n[TW-1:0]] = p;
                                if (p[TW] && n[TW]) bm_n[lv] = 1'b0;
                            end
                            if (kind_reg == pbts_pkg::KIND_CREATE) begin
                                tprio_n[tid_t] = sat_prio;
                                len_we = 1'b1;
                                left_we = 1'b1;
                            end
                            if (kind_reg == pbts_pkg::KIND_REMOVE) begin
                                if (status_reg[tid_t] != pbts_pkg::ST_NOT_READY)
                                    status_n[tid_t] = pbts_pkg::ST_NOT_READY;
                                if (status_reg[tid_t] == pbts_pkg::ST_RUNNING &&
                                    run_valid_reg && run_reg == tid_t)
                                    run_valid_n = 1'b0;
                            end else if (status_reg[tid_t] != pbts_pkg::ST_RUNNING) begin
                                lv = tprio_n[tid_t];
                                o = {1'b0, head_n[lv]};
                                if (bm_n[lv]) begin
                                    next_n[tid_t] = o;
                                    prev_n[o[TW-1:0]] = {1'b0, tid_t};
                                end else begin
                                    next_n[tid_t] = {1'b1, {TW{1'b0}}};
                                end
                                prev_n[tid_t] = {1'b1, {TW{1'b0}}};
                                head_n[lv] = tid_t;
                                bm_n[lv] = 1'b1;
                                status_n[tid_t] = pbts_pkg::ST_READY;
                            end
                        end
                    end
                    pbts_pkg::KIND_START: begin
                        if (!run_valid_reg) begin
                            if (bitmap_reg == '0) err_n = pbts_pkg::ERR_NO_READY;
                            else state_n = S_SCHED;
                            out_load = (bitmap_reg == '0);
                        end
                    end
                    pbts_pkg::KIND_SCHEDULE, pbts_pkg::KIND_TICK: begin
                        if (!run_valid_reg) begin
                            err_n = pbts_pkg::ERR_NO_CUR;
                        end else if (kind_reg == pbts_pkg::KIND_TICK &&
                                     left_rdata > 16'd1) begin
                            left_we = 1'b1;
                            left_waddr = cur;
                            left_wdata = left_rdata - 16'd1;
                        end else begin
                            if (kind_reg == pbts_pkg::KIND_TICK) begin
                                left_we = 1'b1;
                                left_waddr = cur;
                                left_wdata = len_rdata;
                            end
                            if (bitmap_reg == '0) begin
                                err_n = pbts_pkg::ERR_NO_READY;
                            end else if (tprio_reg[cur] >= tprio_reg[best_t]) begin
                                // Put the current thread back at its list head.
                                lv = tprio_reg[cur];
                                o = {1'b0, head_reg[lv]};
                                if (bitmap_reg[lv]) begin
                                    next_n[cur] = o;
                                    prev_n[o[TW-1:0]] = {1'b0, cur};
                                end else begin
                                    next_n[cur] = {1'b1, {TW{1'b0}}};
                                end
                                prev_n[cur] = {1'b1, {TW{1'b0}}};
                                head_n[lv] = cur;
                                bm_n[lv] = 1'b1;
                                status_n[cur] = pbts_pkg::ST_READY;
                                sw_n = 1'b1;
                                from_n = cur;
                                state_n = S_SCHED;
                                out_load = 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCHED: begin
                // Unlink the thread picked in the compute cycle and make it run.
                // The pick is held because the yielding thread may now head its level.
                state_n = S_IDLE;
                out_load = 1'b1;
                sw_n = (kind_reg != pbts_pkg::KIND_START);
                from_n = TW'(out_reg[4:1]);
                cur = pick_reg;
                lv = best_lvl;
                p = prev_reg[cur];
                n = next_reg[cur];
                if (!p[TW]) next_n[p[TW-1:0]] = n;
                else head_n[lv] = n[TW-1:0];
                if (!n[TW]) prev_n[n[TW-1:0]] = p;
                if (p[TW] && n[TW]) bm_n[lv] = 1'b0;
                next_n[cur] = {1'b1, {TW{1'b0}}};
                prev_n[cur] = {1'b1, {TW{1'b0}}};
                status_n[cur] = pbts_pkg::ST_RUNNING;
                run_n = cur;
                run_valid_n = 1'b1;
            end
            default: state_n = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            bitmap_reg <= '0;
            run_valid_reg <= 1'b0;
            run_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++) status_reg[i] <= pbts_pkg::ST_NOT_READY;
        end else begin
            state_reg <= state_n;
            bitmap_reg <= bm_n;
            run_valid_reg <= run_valid_n;
            run_reg <= run_n;
            status_reg <= status_n;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_n;
        next_reg <= next_n;
        prev_reg <= prev_n;
        tprio_reg <= tprio_n;
        if (state_reg == S_EXEC) pick_reg <= best_t;
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tdata[2:0];
            tid_reg <= s_tdata[6:3];
            prio_reg <= s_tdata[11:7];
            slice_reg <= s_tdata[27:12];
        end
        if (sw_n && !out_load) begin
            out_reg[1 +: 4] <= 4'(from_n);
        end
        if (out_load) begin
            out_reg[0] <= sw_n;
            out_reg[4:1] <= sw_n ? 4'(from_n) : 4'd0;
            out_reg[8:5] <= run_valid_n ? 4'(run_n) : 4'd0;
            out_reg[9] <= run_valid_n;
            out_reg[11:10] <= err_n;
        end
    end
endmodule

// File: design/pbts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
